// ===== rtl/srv_pkg.sv =====
// ----------------------------------------------------------------------------
// srv_pkg
// Shared constants, types and fixed-point helpers of the Schroeder reverb.
// ----------------------------------------------------------------------------
package srv_pkg;

  // delay line layout: one shared memory, one 2^POS_W row block per line
  localparam int unsigned LINE_N    = 6;
  localparam int unsigned COMB_N    = 4;
  localparam int unsigned LINE_W    = 3;
  localparam int unsigned POS_W     = 14;
  localparam int unsigned ADDR_W    = LINE_W + POS_W;
  localparam int unsigned MEM_DEPTH = LINE_N << POS_W;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned GAIN_W    = 16;

  // configuration registers
  localparam int unsigned REG_N     = 7;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_WET = REG_IDX_W'(6);

  // line indexes of the two allpass sections
  localparam logic [LINE_W-1:0] LINE_AP0 = LINE_W'(4);
  localparam logic [LINE_W-1:0] LINE_AP1 = LINE_W'(5);

  // default delay lengths
  localparam int unsigned DEF_COMB_DELAY_0    = 9601;
  localparam int unsigned DEF_COMB_DELAY_1    = 9999;
  localparam int unsigned DEF_COMB_DELAY_2    = 10799;
  localparam int unsigned DEF_COMB_DELAY_3    = 11599;
  localparam int unsigned DEF_ALLPASS_DELAY_0 = 7001;
  localparam int unsigned DEF_ALLPASS_DELAY_1 = 2333;

  // symmetric full scale of the output
  localparam logic signed [35:0] FULL_SCALE = 36'sd8388607;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_GD,
    ST_ADD,
    ST_AW,
    ST_AG,
    ST_AS,
    ST_MX1,
    ST_MX2,
    ST_MX3
  } srv_state_e;

  // request to the delay line memory
  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // floor((v + 2^15) / 2^16): round to nearest, ties upward
  function automatic logic signed [35:0] rnd16(input logic signed [51:0] v);
    logic signed [51:0] t;
    t = v + 52'sd32768;
    return t[51:16];
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/schroeder_reverb.sv =====
// ----------------------------------------------------------------------------
// schroeder_reverb
// Four parallel feedback combs, two series allpass sections and a wet/dry
// mix, sequenced over one shared delay memory and one shared multiplier.
// ----------------------------------------------------------------------------
// result: registered in ST_MX3 once the output register is free; no new
//   input is taken before then, as the comb and allpass steps share the
//   single memory port and every product the single multiplier
// reset: a sweep zeroes the delay memory, no input is taken
//   until it ends; configuration writes are taken during the sweep
// ----------------------------------------------------------------------------
module schroeder_reverb import srv_pkg::*; #(
  parameter int unsigned COMB_DELAY_0    = DEF_COMB_DELAY_0,
  parameter int unsigned COMB_DELAY_1    = DEF_COMB_DELAY_1,
  parameter int unsigned COMB_DELAY_2    = DEF_COMB_DELAY_2,
  parameter int unsigned COMB_DELAY_3    = DEF_COMB_DELAY_3,
  parameter int unsigned ALLPASS_DELAY_0 = DEF_ALLPASS_DELAY_0,
  parameter int unsigned ALLPASS_DELAY_1 = DEF_ALLPASS_DELAY_1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [REG_IDX_W-1:0]       cfg_idx_i,
  input  logic [GAIN_W-1:0]          cfg_wdata_i,
  // input samples
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  // output samples
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       clipped_o
);

  // last position of each line, where it wraps
  localparam logic [POS_W-1:0] POS_LAST [LINE_N] = '{
    POS_W'(COMB_DELAY_0 - 1), POS_W'(COMB_DELAY_1 - 1),
    POS_W'(COMB_DELAY_2 - 1), POS_W'(COMB_DELAY_3 - 1),
    POS_W'(ALLPASS_DELAY_0 - 1), POS_W'(ALLPASS_DELAY_1 - 1)
  };

  srv_state_e state_q, state_d;

  logic [GAIN_W-1:0]         gain_q [REG_N];
  logic [POS_W-1:0]          pos_q  [LINE_N];
  logic [LINE_W-1:0]         line_q, line_d;
  logic                      out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                      out_clip_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [33:0]        chain_q;
  logic signed [31:0]        w_q;
  logic [16:0]               h_q;
  logic signed [51:0]        prod_q;
  logic signed [51:0]        acc_q;

  mem_req_t                  mem_req;
  logic [DATA_W-1:0]         mem_rdata;
  logic                      mem_busy;

  logic [GAIN_W-1:0]         gain;
  logic [GAIN_W-1:0]         wet;
  logic [16:0]               dry;
  logic signed [33:0]        mul_a;
  logic signed [17:0]        mul_b;
  logic signed [51:0]        mul_p;
  logic signed [33:0]        stage_in;
  logic signed [35:0]        fb_rnd;
  logic signed [36:0]        fb_sum;
  logic signed [31:0]        fb_y;
  logic signed [35:0]        ap_rnd;
  logic signed [31:0]        ap_out;
  logic signed [35:0]        mix_v;
  logic signed [SAMPLE_W-1:0] mix_sample;
  logic                      mix_clip;
  logic [16:0]               h_next;
  logic                      out_free;
  logic                      in_xfer;
  logic                      out_load;

  srv_line_mem u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // operand selection
  assign gain     = gain_q[line_q];
  assign wet      = gain_q[REG_WET];
  assign dry      = 17'h10000 - {1'b0, wet};
  assign stage_in = (line_q < LINE_AP0) ? {{10{x_q[SAMPLE_W-1]}}, x_q} : chain_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && !mem_busy;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_MX3) && out_free;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_RD: begin
        mul_a = {18'd0, gain};
        mul_b = {2'b00, gain};
      end
      ST_GD: begin
        mul_a = {{2{mem_rdata[DATA_W-1]}}, mem_rdata};
        mul_b = {2'b00, gain};
      end
      ST_AW: begin
        mul_a = {{2{w_q[31]}}, w_q};
        mul_b = {1'b0, h_q};
      end
      ST_AG: begin
        mul_a = chain_q;
        mul_b = {2'b00, gain};
      end
      ST_MX1: begin
        mul_a = chain_q;
        mul_b = {2'b00, wet};
      end
      ST_MX2: begin
        mul_a = {{10{x_q[SAMPLE_W-1]}}, x_q};
        mul_b = {1'b0, dry};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // feedback stage: y = sat32(a + rnd(g*d))
  assign fb_rnd = rnd16(prod_q);
  assign fb_sum = {{3{stage_in[33]}}, stage_in} + {fb_rnd[35], fb_rnd};
  assign fb_y   = sat32({{3{fb_sum[36]}}, fb_sum});

  // (1 - g*g) in unsigned Q1.16 from the registered square
  assign h_next = 17'h10000 - 17'((prod_q[32:0] + 33'd32768) >> 16);

  // allpass output: sat32(rnd(w*h - g*a))
  assign ap_rnd = rnd16(acc_q - prod_q);
  assign ap_out = sat32({{4{ap_rnd[35]}}, ap_rnd});

  // wet/dry mix and symmetric full-scale clamp
  assign mix_v = rnd16(acc_q + prod_q);
  always_comb begin
    mix_clip   = 1'b0;
    mix_sample = mix_v[SAMPLE_W-1:0];
    if (mix_v > FULL_SCALE) begin
      mix_clip   = 1'b1;
      mix_sample = FULL_SCALE[SAMPLE_W-1:0];
    end else if (mix_v < -FULL_SCALE) begin
      mix_clip   = 1'b1;
      mix_sample = -FULL_SCALE[SAMPLE_W-1:0];
    end
  end

  // next state and memory requests
  always_comb begin
    state_d       = state_q;
    line_d        = line_q;
    mem_req.re    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.addr  = {line_q, pos_q[line_q]};
    mem_req.wdata = fb_y;
    unique case (state_q)
      ST_IDLE: begin
        line_d = '0;
        if (in_xfer) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        mem_req.re = 1'b1;
        state_d    = ST_GD;
      end
      ST_GD: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        mem_req.we = 1'b1;
        if (line_q < LINE_AP0) begin
          line_d  = line_q + LINE_W'(1);
          state_d = ST_RD;
        end else begin
          state_d = ST_AW;
        end
      end
      ST_AW: begin
        state_d = ST_AG;
      end
      ST_AG: begin
        state_d = ST_AS;
      end
      ST_AS: begin
        if (line_q == LINE_AP0) begin
          line_d  = LINE_AP1;
          state_d = ST_RD;
        end else begin
          state_d = ST_MX1;
        end
      end
      ST_MX1: begin
        state_d = ST_MX2;
      end
      ST_MX2: begin
        state_d = ST_MX3;
      end
      ST_MX3: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LINE_N; i++) begin
        pos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // every line position advances once per item
      if (out_load) begin
        for (int i = 0; i < LINE_N; i++) begin
          pos_q[i] <= (pos_q[i] == POS_LAST[i]) ? '0 : pos_q[i] + POS_W'(1);
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_N; i++) begin
        gain_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < REG_IDX_W'(REG_N))) begin
      gain_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q     <= sample_in_i;
        chain_q <= '0;
      end
      ST_RD: begin
        prod_q <= mul_p;
      end
      ST_GD: begin
        h_q    <= h_next;
        prod_q <= mul_p;
      end
      ST_ADD: begin
        if (line_q < LINE_AP0) begin
          chain_q <= chain_q + {{2{fb_y[31]}}, fb_y};
        end else begin
          w_q <= fb_y;
        end
      end
      ST_AW: begin
        prod_q <= mul_p;
      end
      ST_AG: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_AS: begin
        chain_q <= {{2{ap_out[31]}}, ap_out};
      end
      ST_MX1: begin
        prod_q <= mul_p;
      end
      ST_MX2: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_MX3: begin
        if (out_free) begin
          out_sample_q <= mix_sample;
          out_clip_q   <= mix_clip;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

endmodule

// ===== rtl/srv_line_mem.sv =====
// ----------------------------------------------------------------------------
// srv_line_mem
// Single-port delay line memory with registered read data and a clearing
// sweep after reset that writes zero to every entry.
// ----------------------------------------------------------------------------
module srv_line_mem import srv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              busy_o
);

  logic [DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
    end
  end

  // memory port
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else begin
      if (req_i.we) begin
        mem_q[req_i.addr] <= req_i.wdata;
      end
      if (req_i.re) begin
        rdata_q <= mem_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule
